[src/api_pkg.sv]
// shared types, constants and register codes for the ata pio command issuer
// no dependencies; compiled first
`default_nettype none

package api_pkg;

    localparam int LBA_W      = 48;
    localparam int CNT_W      = 16;
    localparam int SHIFT_W    = 4;
    localparam int ALIGN_W    = 14;
    localparam int LOW_W      = 28;
    localparam int HIGH_W     = 48;
    localparam int SUM_W      = 50;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int OFF_W      = 3;
    localparam int VAL_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int STEP_W     = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_ISSUED     = 2'd0,
        ST_NO_DRIVE   = 2'd1,
        ST_ZERO_COUNT = 2'd2,
        ST_RANGE      = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_SELECT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SHIFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_SUPPORTED = 3'd6;

    localparam logic [OFF_W-1:0] OFF_NONE     = 3'd0;
    localparam logic [OFF_W-1:0] OFF_COUNT    = 3'd2;
    localparam logic [OFF_W-1:0] OFF_LBA_LOW  = 3'd3;
    localparam logic [OFF_W-1:0] OFF_LBA_MID  = 3'd4;
    localparam logic [OFF_W-1:0] OFF_LBA_HIGH = 3'd5;
    localparam logic [OFF_W-1:0] OFF_DRIVE    = 3'd6;
    localparam logic [OFF_W-1:0] OFF_CMD      = 3'd7;

    localparam logic [VAL_W-1:0] CMD_READ28   = 8'h20;
    localparam logic [VAL_W-1:0] CMD_WRITE28  = 8'h30;
    localparam logic [VAL_W-1:0] CMD_READ48   = 8'h24;
    localparam logic [VAL_W-1:0] CMD_WRITE48  = 8'h34;
    localparam logic [VAL_W-1:0] DRIVE_LBA28  = 8'hE0;
    localparam logic [VAL_W-1:0] DRIVE_LBA48  = 8'h40;

    localparam logic [CNT_W-1:0] MAX_COUNT28 = 16'd256;

    localparam logic [STEP_W-1:0] RES_ERR = 4'd1;
    localparam logic [STEP_W-1:0] RES_28  = 4'd6;
    localparam logic [STEP_W-1:0] RES_48  = 4'd10;

    typedef struct packed {
        logic                drive_present;
        logic                slave_select;
        logic [SHIFT_W-1:0]  sector_shift;
        logic [ALIGN_W-1:0]  align_offset;
        logic [LOW_W-1:0]    low_limit;
        logic [HIGH_W-1:0]   high_limit;
        logic                ext_supported;
    } t_cfg;

    typedef struct packed {
        logic               wr;
        logic               zero;
        logic [SUM_W-1:0]   s_start;
        logic [SUM_W-1:0]   s_fin;
    } t_sums;

    typedef struct packed {
        logic               wr;
        logic               zero;
        logic [LBA_W-1:0]   start;
        logic [SUM_W-1:0]   fin;
    } t_addr;

    typedef struct packed {
        t_status            status;
        logic               ext;
        logic               wr;
        logic               sel;
        logic [LBA_W-1:0]   start;
        logic [CNT_W-1:0]   pc;
    } t_job;

endpackage

`default_nettype wire

[src/api_if.sv]
// valid/ready channel interfaces: request, result and config write
// depends on api_pkg for field widths
`default_nettype none

interface api_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [api_pkg::LBA_W-1:0]   lba;
    logic [api_pkg::CNT_W-1:0]   blk_count;

    modport source (output valid, command, lba, blk_count, input ready);
    modport sink   (input valid, command, lba, blk_count, output ready);
endinterface

interface api_res_if;
    logic                          valid;
    logic                          ready;
    logic [api_pkg::OFF_W-1:0]     port_offset;
    logic [api_pkg::VAL_W-1:0]     port_value;
    logic [api_pkg::STATUS_W-1:0]  status;
    logic                          last;

    modport source (output valid, port_offset, port_value, status, last, input ready);
    modport sink   (input valid, port_offset, port_value, status, last, output ready);
endinterface

interface api_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [api_pkg::CFG_IDX_W-1:0]   index;
    logic [api_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/api_addr.sv]
// address stages: aligned sums, then shift to physical start and end sectors
// depends on api_pkg
`default_nettype none

module api_addr (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_command,
    input  wire logic [api_pkg::LBA_W-1:0]   i_lba,
    input  wire logic [api_pkg::CNT_W-1:0]   i_count,
    input  wire api_pkg::t_cfg               i_cfg,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output api_pkg::t_addr                   o_addr
);
    import api_pkg::*;

    logic  r_s1_valid;
    t_sums r_s1;
    t_sums n_s1;
    logic  r_s2_valid;
    t_addr r_s2;
    t_addr n_s2;
    logic  s1_ready;
    logic  s2_ready;

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    always_comb begin
        n_s1.wr      = i_command;
        n_s1.zero    = (i_count == '0);
        n_s1.s_start = {{(SUM_W-LBA_W){1'b0}}, i_lba} + SUM_W'(i_cfg.align_offset);
        n_s1.s_fin   = n_s1.s_start + SUM_W'(i_count);
    end

    always_comb begin
        n_s2.wr    = r_s1.wr;
        n_s2.zero  = r_s1.zero;
        n_s2.start = LBA_W'(r_s1.s_start >> i_cfg.sector_shift);
        n_s2.fin   = r_s1.s_fin >> i_cfg.sector_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1 <= n_s1;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_ready = s1_ready;
    assign o_valid = r_s2_valid;
    assign o_addr  = r_s2;

endmodule

`default_nettype wire

[src/api_form.sv]
// form selection: physical count, lba28/lba48 choice and error status
// depends on api_pkg
`default_nettype none

module api_form (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire api_pkg::t_addr   i_addr,
    input  wire api_pkg::t_cfg    i_cfg,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output api_pkg::t_job         o_job
);
    import api_pkg::*;

    logic             r_valid;
    t_job             r_job;
    t_job             n_job;
    logic [CNT_W-1:0] pc;
    logic             fits28;
    logic             range_err;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        pc        = i_addr.fin[CNT_W-1:0] - i_addr.start[CNT_W-1:0] + CNT_W'(1);
        fits28    = (i_addr.fin <= SUM_W'(i_cfg.low_limit)) && (pc <= MAX_COUNT28);
        range_err = (i_addr.fin > SUM_W'(i_cfg.high_limit)) && !i_cfg.ext_supported;
        n_job.wr    = i_addr.wr;
        n_job.sel   = i_cfg.slave_select;
        n_job.start = i_addr.start;
        n_job.pc    = pc;
        n_job.ext   = 1'b0;
        if (!i_cfg.drive_present) begin
            n_job.status = ST_NO_DRIVE;
        end else if (i_addr.zero) begin
            n_job.status = ST_ZERO_COUNT;
        end else if (fits28) begin
            n_job.status = ST_ISSUED;
        end else if (range_err) begin
            n_job.status = ST_RANGE;
        end else begin
            n_job.status = ST_ISSUED;
            n_job.ext    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

`default_nettype wire

[src/api_emit.sv]
// write sequencer: steps through the task-file writes of one job into an output register
// depends on api_pkg
`default_nettype none

module api_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire api_pkg::t_job                 i_job,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [api_pkg::OFF_W-1:0]          o_port_offset,
    output logic [api_pkg::VAL_W-1:0]          o_port_value,
    output logic [api_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_last
);
    import api_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_k;
    t_job              r_job;
    logic              r_out_valid;
    logic [OFF_W-1:0]  r_out_offset;
    logic [VAL_W-1:0]  r_out_value;
    t_status           r_out_status;
    logic              r_out_last;

    logic [STEP_W-1:0] n_res;
    logic              cur_last;
    logic [OFF_W-1:0]  cur_offset;
    logic [VAL_W-1:0]  cur_value;
    logic              out_load;
    logic              job_take;

    always_comb begin
        if (r_job.status != ST_ISSUED) begin
            n_res = RES_ERR;
        end else if (r_job.ext) begin
            n_res = RES_48;
        end else begin
            n_res = RES_28;
        end
    end

    assign cur_last = (r_k == n_res - STEP_W'(1));
    assign out_load = r_busy && (!r_out_valid || i_ready);
    assign job_take = !r_busy || (out_load && cur_last);

    always_comb begin
        cur_offset = OFF_NONE;
        cur_value  = '0;
        if (r_job.status != ST_ISSUED) begin
            cur_offset = OFF_NONE;
            cur_value  = '0;
        end else if (!r_job.ext) begin
            case (r_k)
                4'd0: begin
                    cur_offset = OFF_DRIVE;
                    cur_value  = DRIVE_LBA28 | {3'b000, r_job.sel, r_job.start[27:24]};
                end
                4'd1: begin
                    cur_offset = OFF_LBA_LOW;
                    cur_value  = r_job.start[7:0];
                end
                4'd2: begin
                    cur_offset = OFF_LBA_MID;
                    cur_value  = r_job.start[15:8];
                end
                4'd3: begin
                    cur_offset = OFF_LBA_HIGH;
                    cur_value  = r_job.start[23:16];
                end
                4'd4: begin
                    cur_offset = OFF_COUNT;
                    cur_value  = r_job.pc[7:0];
                end
                default: begin
                    cur_offset = OFF_CMD;
                    cur_value  = r_job.wr ? CMD_WRITE28 : CMD_READ28;
                end
            endcase
        end else begin
            case (r_k)
                4'd0: begin
                    cur_offset = OFF_DRIVE;
                    cur_value  = DRIVE_LBA48 | {3'b000, r_job.sel, 4'b0000};
                end
                4'd1: begin
                    cur_offset = OFF_COUNT;
                    cur_value  = r_job.pc[15:8];
                end
                4'd2: begin
                    cur_offset = OFF_LBA_LOW;
                    cur_value  = r_job.start[31:24];
                end
                4'd3: begin
                    cur_offset = OFF_LBA_MID;
                    cur_value  = r_job.start[39:32];
                end
                4'd4: begin
                    cur_offset = OFF_LBA_HIGH;
                    cur_value  = r_job.start[47:40];
                end
                4'd5: begin
                    cur_offset = OFF_COUNT;
                    cur_value  = r_job.pc[7:0];
                end
                4'd6: begin
                    cur_offset = OFF_LBA_LOW;
                    cur_value  = r_job.start[7:0];
                end
                4'd7: begin
                    cur_offset = OFF_LBA_MID;
                    cur_value  = r_job.start[15:8];
                end
                4'd8: begin
                    cur_offset = OFF_LBA_HIGH;
                    cur_value  = r_job.start[23:16];
                end
                default: begin
                    cur_offset = OFF_CMD;
                    cur_value  = r_job.wr ? CMD_WRITE48 : CMD_READ48;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (job_take) begin
                r_busy <= i_valid;
                r_k    <= '0;
            end else if (out_load) begin
                r_k <= r_k + STEP_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_take && i_valid) begin
            r_job <= i_job;
        end
        if (out_load) begin
            r_out_offset <= cur_offset;
            r_out_value  <= cur_value;
            r_out_status <= r_job.status;
            r_out_last   <= cur_last;
        end
    end

    assign o_ready       = job_take;
    assign o_valid       = r_out_valid;
    assign o_port_offset = r_out_offset;
    assign o_port_value  = r_out_value;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

    // error results are single items
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != ST_ISSUED) |-> r_out_last)
        else $error("error result without last");

    // the command byte closes every issued request
    a_cmd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_offset == OFF_CMD) |-> r_out_last)
        else $error("command byte not marked last");

    // a new job replaces the current one only as its final write goes out
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && job_take |-> out_load && cur_last)
        else $error("job replaced before its final write");

    // the step counter advances by one per emitted write
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && out_load && !cur_last |=> r_busy && (r_k == $past(r_k) + STEP_W'(1)))
        else $error("step counter skipped");

endmodule

`default_nettype wire

[src/ata_pio_command_issuer_core.sv]
// ata pio command issuer: turns a read/write sector request into task-file register writes
// channels: request (i_req, sink), result (o_res, source), config write (i_cfg, sink)
// depends on api_pkg, api_if, api_addr, api_form, api_emit
//
// a request carries command, lba and blk_count; it is mapped to physical start and
// end sectors and emitted as an lba28 run of six writes, an lba48 run of ten writes, or
// a single error item (no drive, zero count, out of range). last marks the final item.
// after a request is accepted it passes the sum register, shift register, job register,
// sequencer job register and output register before the first result item is valid.
// throughput: one result item per cycle while the receiver is ready; the sequencer
// holds one job at a time, so a request occupies the result channel for its 1, 6 or 10 items.
// up to three further requests are taken into the address and job stages meanwhile.
// a stalled receiver holds the output register; back pressure fills the stages and then
// drops i_req.ready. config writes are always accepted (i_cfg.ready is high) and must
// only happen while the block is idle. unknown register indexes are ignored.
// reset clears all config registers to zero and empties every stage.
`default_nettype none

module ata_pio_command_issuer_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    api_req_if.sink    i_req,
    api_res_if.source  o_res,
    api_cfg_if.sink    i_cfg
);
    import api_pkg::*;

    t_cfg  r_cfg;
    logic  addr_valid;
    logic  addr_ready;
    t_addr addr;
    logic  job_valid;
    logic  job_ready;
    t_job  job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DRIVE_PRESENT: r_cfg.drive_present <= i_cfg.data[0];
                CFG_SLAVE_SELECT:  r_cfg.slave_select  <= i_cfg.data[0];
                CFG_SECTOR_SHIFT:  r_cfg.sector_shift  <= i_cfg.data[SHIFT_W-1:0];
                CFG_ALIGN_OFFSET:  r_cfg.align_offset  <= i_cfg.data[ALIGN_W-1:0];
                CFG_LOW_LIMIT:     r_cfg.low_limit     <= i_cfg.data[LOW_W-1:0];
                CFG_HIGH_LIMIT:    r_cfg.high_limit    <= i_cfg.data[HIGH_W-1:0];
                CFG_EXT_SUPPORTED: r_cfg.ext_supported <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    api_addr u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .o_ready   (i_req.ready),
        .i_command (i_req.command),
        .i_lba     (i_req.lba),
        .i_count   (i_req.blk_count),
        .i_cfg     (r_cfg),
        .o_valid   (addr_valid),
        .i_ready   (addr_ready),
        .o_addr    (addr)
    );

    api_form u_form (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (addr_valid),
        .o_ready (addr_ready),
        .i_addr  (addr),
        .i_cfg   (r_cfg),
        .o_valid (job_valid),
        .i_ready (job_ready),
        .o_job   (job)
    );

    api_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (job_valid),
        .o_ready       (job_ready),
        .i_job         (job),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_port_offset (o_res.port_offset),
        .o_port_value  (o_res.port_value),
        .o_status      (o_res.status),
        .o_last        (o_res.last)
    );

endmodule

`default_nettype wire
